// ===== src/id3v2_picture_frame_finder_top_defines.svh =====
// Assertion macros used by the ID3v2 picture frame finder checker.
`ifndef ID3V2_PICTURE_FRAME_FINDER_TOP_DEFINES_SVH
`define ID3V2_PICTURE_FRAME_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ID3PF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("id3pf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ID3PF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("id3pf: next-cycle check failed");

`endif

// ===== src/id3pf_pkg.sv =====
// Types, codes and text tables of the ID3v2 picture frame finder.
`default_nettype none

package id3pf_pkg;

  localparam int unsigned MAX_TEXT_BYTES_DEF = 65;
  localparam int unsigned POS_W              = 29;
  localparam int unsigned LEN_W              = 28;
  localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
  // header 10, frame header 10, encoding 1, "image/png" and zero 10, type 1, empty desc 1
  localparam int unsigned MIN_IMAGE_OFFSET   = 33;

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_JPEG = 2'd1;
  localparam logic [1:0] VERDICT_PNG  = 2'd2;
  localparam logic [1:0] VERDICT_BAD  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FRAME,
    PH_SKIP,
    PH_ENCODING,
    PH_MIME,
    PH_PICTYPE,
    PH_DESC
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_tag;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [POS_W-1:0] image_offset;
  } res_t;

  function automatic logic [7:0] sig_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = "I";
      2'd1:    c = "D";
      2'd2:    c = "3";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] apic_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = "A";
      2'd1:    c = "P";
      2'd2:    c = "I";
      default: c = "C";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] jpeg_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "i";
      4'd1:    c = "m";
      4'd2:    c = "a";
      4'd3:    c = "g";
      4'd4:    c = "e";
      4'd5:    c = "/";
      4'd6:    c = "j";
      4'd7:    c = "p";
      4'd8:    c = "e";
      4'd9:    c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] png_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "i";
      4'd1:    c = "m";
      4'd2:    c = "a";
      4'd3:    c = "g";
      4'd4:    c = "e";
      4'd5:    c = "/";
      4'd6:    c = "p";
      4'd7:    c = "n";
      4'd8:    c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/id3v2_picture_frame_finder_top.sv =====
// Top level of the ID3v2 picture frame finder.
//
//   channel  dir  tdata                        tuser              tlast
//   s_axis   in   [7:0] data_byte              [0] start_of_tag   end_of_data
//   m_axis   out  [28:0] image_offset, pad 0   [1:0] verdict      -
//
// One byte per cycle unless the sink stalls; a byte enters the input register,
// is parsed once the result register is free, and its verdict, if any, is
// loaded there as the byte is taken. The per-byte counter, compare and shift
// step of the parser sets the rate. Reset returns the parser to idle and
// empties both registers. A stalled sink holds the result word; the input
// still takes one more byte and stalls only while both registers are full.
`default_nettype none

module id3v2_picture_frame_finder_top #(
  parameter int unsigned MaxTextBytes = id3pf_pkg::MAX_TEXT_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] start_of_tag
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [28:0] image_offset, [31:29] zero
  output logic [1:0]       m_axis_tuser_o    // [1:0] verdict
);
  import id3pf_pkg::*;

  in_item_t s_item, item;
  res_t     res, m_res;
  logic     item_valid, take, free, res_valid;

  assign s_item.data_byte    = s_axis_tdata_i;
  assign s_item.start_of_tag = s_axis_tuser_i;
  assign s_item.end_of_data  = s_axis_tlast_i;

  id3pf_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_item_i     (s_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (take)
  );

  // parse only when the result register can hold what comes out
  assign take = item_valid && free;

  id3pf_parser #(
    .MaxTextBytes (MaxTextBytes)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  id3pf_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (take && res_valid),
    .res_i     (res),
    .free_o    (free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = {{(32 - POS_W){1'b0}}, m_res.image_offset};
  assign m_axis_tuser_o = m_res.verdict;

endmodule

`default_nettype wire

// ===== src/id3pf_in_stage.sv =====
// Input register that holds one stream word until the parser takes it.
`default_nettype none

module id3pf_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire id3pf_pkg::in_item_t s_item_i,
  output logic                    item_valid_o,
  output id3pf_pkg::in_item_t     item_o,
  input  wire logic               item_take_i
);
  import id3pf_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // refill in the same cycle the held word drains
  assign s_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== src/id3pf_parser.sv =====
// Tag parser: header check, frame walk and APIC mime/description scan per byte.
`default_nettype none

module id3pf_parser #(
  parameter int unsigned MaxTextBytes = id3pf_pkg::MAX_TEXT_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire id3pf_pkg::in_item_t item_i,
  output logic                     res_valid_o,
  output id3pf_pkg::res_t          res_o
);
  import id3pf_pkg::*;

  localparam int unsigned CntMax = (MaxTextBytes > 10) ? MaxTextBytes : 10;
  localparam int unsigned CntW   = $clog2(CntMax + 1);

  phase_e           phase_q, phase_d, cur_phase, step_phase;
  logic [CntW-1:0]  cnt_q, cnt_d, cur_cnt, cnt_inc;
  logic [POS_W-1:0] pos_q, pos_d, cur_pos;
  logic [LEN_W-1:0] len_q, len_d, cur_len;
  logic [7:0]       ver_q, ver_d, cur_ver;
  logic             sig_q, sig_d, cur_sig;
  logic [31:0]      size_q, size_d, cur_size;
  logic             pic_q, pic_d, cur_pic;
  logic             jm_q, jm_d, cur_jm;
  logic             pm_q, pm_d, cur_pm;
  logic [1:0]       kind_q, kind_d, cur_kind;

  logic             fin, eod, begin_frm, end_chk, past_end, sig_ok;
  logic [1:0]       fin_verdict;
  logic [POS_W-1:0] fin_offset;
  logic [7:0]       b;

  assign b = item_i.data_byte;

  // start of tag clears everything and opens the header
  always_comb begin
    cur_phase = phase_q;
    cur_cnt   = cnt_q;
    cur_pos   = pos_q;
    cur_len   = len_q;
    cur_ver   = ver_q;
    cur_sig   = sig_q;
    cur_size  = size_q;
    cur_pic   = pic_q;
    cur_jm    = jm_q;
    cur_pm    = pm_q;
    cur_kind  = kind_q;
    if (item_i.start_of_tag) begin
      cur_phase = PH_HEADER;
      cur_cnt   = '0;
      cur_pos   = '0;
      cur_len   = '0;
      cur_ver   = '0;
      cur_sig   = 1'b0;
      cur_size  = '0;
      cur_pic   = 1'b0;
      cur_jm    = 1'b0;
      cur_pm    = 1'b0;
      cur_kind  = VERDICT_NONE;
    end
  end

  assign cnt_inc = cur_cnt + 1'b1;

  // per-byte datapath step
  always_comb begin
    step_phase  = cur_phase;
    cnt_d       = cur_cnt;
    len_d       = cur_len;
    ver_d       = cur_ver;
    sig_d       = cur_sig;
    size_d      = cur_size;
    pic_d       = cur_pic;
    jm_d        = cur_jm;
    pm_d        = cur_pm;
    kind_d      = cur_kind;
    fin         = 1'b0;
    fin_verdict = VERDICT_NONE;
    fin_offset  = '0;
    begin_frm   = 1'b0;
    end_chk     = 1'b0;
    sig_ok      = 1'b0;
    pos_d       = cur_pos;
    if (cur_phase != PH_IDLE && cur_pos != POS_MAX) begin
      pos_d = cur_pos + 1'b1;
    end

    unique case (cur_phase)
      PH_IDLE: begin
      end
      PH_HEADER: begin
        if (cur_cnt < CntW'(3)) begin
          sig_ok = (b == sig_char(cur_cnt[1:0]));
          sig_d  = (cur_cnt == '0) ? sig_ok : (cur_sig && sig_ok);
        end else if (cur_cnt == CntW'(3)) begin
          ver_d = b;
        end else if (cur_cnt >= CntW'(6)) begin
          len_d = {cur_len[LEN_W-8:0], b[6:0]};
        end
        cnt_d = cnt_inc;
        if (cur_cnt >= CntW'(9)) begin
          if (!sig_d || (ver_d != 8'd3 && ver_d != 8'd4)) begin
            fin         = 1'b1;
            fin_verdict = VERDICT_BAD;
          end else begin
            begin_frm = 1'b1;
          end
        end
      end
      PH_FRAME: begin
        if (cur_cnt < CntW'(4)) begin
          pic_d = cur_pic && (b == apic_char(cur_cnt[1:0]));
        end else if (cur_cnt < CntW'(8)) begin
          if (cur_ver == 8'd3) begin
            size_d = {cur_size[23:0], b};
          end else begin
            size_d = {4'b0000, cur_size[20:0], b[6:0]};
          end
        end
        cnt_d = cnt_inc;
        if (cur_cnt >= CntW'(9)) begin
          if (cur_pic) begin
            step_phase = PH_ENCODING;
          end else if (cur_size == '0) begin
            begin_frm = 1'b1;
          end else begin
            step_phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (cur_size != '0) begin
          size_d = cur_size - 1'b1;
        end
        end_chk   = 1'b1;
        begin_frm = (size_d == '0);
      end
      PH_ENCODING: begin
        step_phase = PH_MIME;
        cnt_d      = '0;
        jm_d       = 1'b1;
        pm_d       = 1'b1;
      end
      PH_MIME: begin
        if (b == 8'h00) begin
          if (cur_jm && cur_cnt == CntW'(10)) begin
            kind_d = VERDICT_JPEG;
          end else if (cur_pm && cur_cnt == CntW'(9)) begin
            kind_d = VERDICT_PNG;
          end else begin
            kind_d = VERDICT_NONE;
          end
          step_phase = PH_PICTYPE;
        end else begin
          jm_d  = cur_jm && (cur_cnt < CntW'(10)) && (b == jpeg_char(cur_cnt[3:0]));
          pm_d  = cur_pm && (cur_cnt < CntW'(9)) && (b == png_char(cur_cnt[3:0]));
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(MaxTextBytes)) begin
            fin = 1'b1;
          end
        end
      end
      PH_PICTYPE: begin
        step_phase = PH_DESC;
        cnt_d      = '0;
      end
      PH_DESC: begin
        if (b == 8'h00) begin
          fin = 1'b1;
          if (cur_kind == VERDICT_JPEG || cur_kind == VERDICT_PNG) begin
            fin_verdict = cur_kind;
            fin_offset  = pos_d;
          end
        end else begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(MaxTextBytes)) begin
            fin = 1'b1;
          end
        end
      end
      default: begin
        step_phase = PH_IDLE;
      end
    endcase

    // frame headers and skips stop at the end of the tag
    past_end = (pos_d >= ({1'b0, len_d} + POS_W'(10)));
    if ((begin_frm || end_chk) && past_end) begin
      fin = 1'b1;
    end else if (begin_frm) begin
      step_phase = PH_FRAME;
      cnt_d      = '0;
      pic_d      = 1'b1;
      size_d     = '0;
    end
  end

  assign eod = item_i.end_of_data && !fin && (step_phase != PH_IDLE);

  // next state
  always_comb begin
    phase_d = step_phase;
    if (fin || eod) begin
      phase_d = PH_IDLE;
    end
  end

  // result
  always_comb begin
    res_valid_o        = fin || eod;
    res_o.verdict      = fin_verdict;
    res_o.image_offset = fin_offset;
    if (!fin) begin
      res_o.verdict      = (step_phase == PH_HEADER) ? VERDICT_BAD : VERDICT_NONE;
      res_o.image_offset = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      ver_q   <= '0;
      sig_q   <= 1'b0;
      size_q  <= '0;
      pic_q   <= 1'b0;
      jm_q    <= 1'b0;
      pm_q    <= 1'b0;
      kind_q  <= VERDICT_NONE;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      ver_q   <= ver_d;
      sig_q   <= sig_d;
      size_q  <= size_d;
      pic_q   <= pic_d;
      jm_q    <= jm_d;
      pm_q    <= pm_d;
      kind_q  <= kind_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/id3pf_out_stage.sv =====
// Result register that holds one verdict word until the sink takes it.
`default_nettype none

module id3pf_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire id3pf_pkg::res_t res_i,
  output logic                 free_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output id3pf_pkg::res_t      m_res_o
);
  import id3pf_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

`default_nettype wire

// ===== src/id3pf_checker.sv =====
// Port-level checks of the ID3v2 picture frame finder, bound to the top level.
`default_nettype none
`include "id3v2_picture_frame_finder_top_defines.svh"

module id3pf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [7:0]  s_axis_tdata_i,
  input wire logic        s_axis_tuser_i,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);
  import id3pf_pkg::*;

  logic out_stall, out_none, out_pic, out_off_ok;

  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_none   = m_axis_tvalid_o &&
                      (m_axis_tuser_o == VERDICT_NONE || m_axis_tuser_o == VERDICT_BAD);
  assign out_pic    = m_axis_tvalid_o &&
                      (m_axis_tuser_o == VERDICT_JPEG || m_axis_tuser_o == VERDICT_PNG);
  assign out_off_ok = (m_axis_tdata_o >= 32'(MIN_IMAGE_OFFSET)) &&
                      (m_axis_tdata_o[31:29] == 3'b000);

  // a stalled result word holds
  `ID3PF_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable({m_axis_tdata_o, m_axis_tuser_o}))

  // input backpressure only when both registers are full
  `ID3PF_ASSERT_NOW(a_stall_cause, !s_axis_tready_o, out_stall)

  // no picture means no offset
  `ID3PF_ASSERT_NOW(a_zero_offset, out_none, m_axis_tdata_o == 32'd0)

  // a picture cannot start before the shortest possible APIC layout ends
  `ID3PF_ASSERT_NOW(a_min_offset, out_pic, out_off_ok)

endmodule

bind id3v2_picture_frame_finder_top id3pf_checker u_id3pf_checker (.*);

`default_nettype wire

// ===== tb/sv/id3v2_picture_frame_finder_top_tb.sv =====
// Testbench for the ID3v2 picture frame finder: random tags, byte-level predictor, scoreboard.
`timescale 1ns / 1ps

module id3v2_picture_frame_finder_top_tb;
  import id3pf_pkg::*;

  localparam int unsigned ItemTarget = 1850;
  localparam int unsigned HoldCycles = 400;

  // Tracks the parser byte by byte and keeps the verdicts still owed by the block.
  class apic_verdict_tracker;
    phase_e      phase;
    int unsigned fcount;
    logic [28:0] pos;
    logic [27:0] tlen;
    logic [7:0]  major;
    bit          sig_ok;
    bit          is_apic;
    bit          jpeg_ok;
    bit          png_ok;
    bit          done;
    logic [31:0] fsize;
    logic [31:0] skip_left;
    logic [1:0]  kind;
    res_t        outcome;
    res_t        pending_verdicts[$];
    int unsigned errors;
    string       sig_txt;
    string       apic_txt;
    string       jpeg_txt;
    string       png_txt;

    function new();
      sig_txt  = "ID3";
      apic_txt = "APIC";
      jpeg_txt = "image/jpeg";
      png_txt  = "image/png";
      errors   = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_IDLE;
      fcount    = 0;
      pos       = '0;
      tlen      = '0;
      major     = '0;
      sig_ok    = 1'b0;
      fsize     = '0;
      skip_left = '0;
      is_apic   = 1'b0;
      jpeg_ok   = 1'b0;
      png_ok    = 1'b0;
      kind      = VERDICT_NONE;
    endfunction

    function void conclude(logic [1:0] v, logic [28:0] off);
      done                 = 1'b1;
      outcome.verdict      = v;
      outcome.image_offset = off;
      phase                = PH_IDLE;
    endfunction

    function bit beyond_tag();
      return {3'b000, pos} >= ({4'b0000, tlen} + 32'd10);
    endfunction

    function void open_frame();
      if (beyond_tag()) begin
        conclude(VERDICT_NONE, '0);
      end else begin
        phase   = PH_FRAME;
        fcount  = 0;
        is_apic = 1'b1;
        fsize   = '0;
      end
    endfunction

    // Returns 1 when the parser took the word, 0 when it was ignored while idle.
    function bit parse_byte(logic [7:0] b, logic sot, logic eod);
      int unsigned i;
      done = 1'b0;
      if (sot) begin
        restart();
        phase = PH_HEADER;
      end
      if (phase == PH_IDLE) return 1'b0;
      if (pos != POS_MAX) pos++;
      i = fcount;
      case (phase)
        PH_HEADER: begin
          if (i < 3) sig_ok = (i == 0 ? 1'b1 : sig_ok) && (b == sig_txt[i]);
          else if (i == 3) major = b;
          else if (i >= 6) tlen = {tlen[20:0], b[6:0]};
          fcount = i + 1;
          if (i >= 9) begin
            if (!sig_ok || (major != 8'd3 && major != 8'd4)) conclude(VERDICT_BAD, '0);
            else open_frame();
          end
        end
        PH_FRAME: begin
          if (i < 4) begin
            is_apic = is_apic && (b == apic_txt[i]);
          end else if (i < 8) begin
            if (major == 8'd3) fsize = {fsize[23:0], b};
            else fsize = {4'b0000, fsize[20:0], b[6:0]};
          end
          fcount = i + 1;
          if (i >= 9) begin
            if (is_apic) begin
              phase = PH_ENCODING;
            end else begin
              skip_left = fsize;
              if (skip_left == 0) open_frame();
              else phase = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (skip_left != 0) skip_left--;
          if (beyond_tag()) conclude(VERDICT_NONE, '0);
          else if (skip_left == 0) open_frame();
        end
        PH_ENCODING: begin
          phase   = PH_MIME;
          fcount  = 0;
          jpeg_ok = 1'b1;
          png_ok  = 1'b1;
        end
        PH_MIME: begin
          if (b == 8'h00) begin
            if (jpeg_ok && i == 10) kind = VERDICT_JPEG;
            else if (png_ok && i == 9) kind = VERDICT_PNG;
            else kind = VERDICT_NONE;
            phase = PH_PICTYPE;
          end else begin
            if (i >= 10) jpeg_ok = 1'b0;
            else jpeg_ok = jpeg_ok && (b == jpeg_txt[i]);
            if (i >= 9) png_ok = 1'b0;
            else png_ok = png_ok && (b == png_txt[i]);
            fcount = i + 1;
            if (fcount >= MAX_TEXT_BYTES_DEF) conclude(VERDICT_NONE, '0);
          end
        end
        PH_PICTYPE: begin
          phase  = PH_DESC;
          fcount = 0;
        end
        PH_DESC: begin
          if (b == 8'h00) begin
            if (kind == VERDICT_JPEG || kind == VERDICT_PNG) conclude(kind, pos);
            else conclude(VERDICT_NONE, '0);
          end else begin
            fcount = i + 1;
            if (fcount >= MAX_TEXT_BYTES_DEF) conclude(VERDICT_NONE, '0);
          end
        end
        default: phase = PH_IDLE;
      endcase
      // last byte of the stream closes any open tag
      if (!done && eod && phase != PH_IDLE)
        conclude(phase == PH_HEADER ? VERDICT_BAD : VERDICT_NONE, '0);
      if (done) pending_verdicts.push_back(outcome);
      return 1'b1;
    endfunction

    function void match_verdict(logic [1:0] v, logic [31:0] word);
      res_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual verdict %0d offset %0d",
                 $time, v, word[28:0]);
        return;
      end
      want = pending_verdicts.pop_front();
      if (v !== want.verdict) begin
        errors++;
        $display("%0t: verdict mismatch: expected %0d, actual %0d", $time, want.verdict, v);
      end
      if (word[28:0] !== want.image_offset) begin
        errors++;
        $display("%0t: image offset mismatch: expected %0d, actual %0d",
                 $time, want.image_offset, word[28:0]);
      end
      if (word[31:29] !== 3'b000) begin
        errors++;
        $display("%0t: tdata pad mismatch: expected 0, actual %0d", $time, word[31:29]);
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        s_axis_tuser_i  = 1'b0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  apic_verdict_tracker tracker = new();
  logic [7:0]  tag_bytes[$];
  int unsigned parsed_bytes  = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  bit          hold_request  = 1'b0;

  id3v2_picture_frame_finder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: check every accepted word, then pick tready for the next cycle.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        tracker.match_verdict(m_axis_tuser_o, m_axis_tdata_o);
      if (hold_left == 0 && hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sot, input logic eod);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= sot;
    s_axis_tlast_i  <= eod;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (tracker.parse_byte(b, sot, eod)) parsed_bytes++;
  endtask

  // Send the first count bytes of the tag, optionally marking the last one as end of data.
  task automatic send_tag(input int unsigned count, input bit mark_end);
    for (int unsigned k = 0; k < count; k++)
      send_byte(tag_bytes[k], k == 0, mark_end && (k == count - 1));
  endtask

  function automatic logic [7:0] any_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  // Seven bits per byte; the top bit is junk that the parser must mask.
  function automatic void put_synchsafe(logic [27:0] v);
    for (int k = 3; k >= 0; k--)
      tag_bytes.push_back({1'($urandom_range(1)), v[7*k +: 7]});
  endfunction

  function automatic void put_word32(logic [31:0] v);
    for (int k = 3; k >= 0; k--) tag_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_text(string s);
    for (int k = 0; k < s.len(); k++) tag_bytes.push_back(s[k]);
  endfunction

  function automatic void build_tag();
    int unsigned n_frames;
    int unsigned pick;
    int unsigned body;
    int unsigned dlen;
    int unsigned mut_idx;
    logic [31:0] fsz;
    logic [27:0] tlen;
    logic [7:0]  major;
    string       mime;
    tag_bytes.delete();
    major = ($urandom_range(11) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3, 4));
    put_text("ID3");
    if ($urandom_range(11) == 0) tag_bytes[$urandom_range(2)] = 8'($urandom_range(255));
    tag_bytes.push_back(major);
    tag_bytes.push_back(8'($urandom_range(255)));
    tag_bytes.push_back(8'($urandom_range(255)));
    put_word32('0);
    n_frames = $urandom_range(0, 3);
    repeat (n_frames) begin
      // other frames, a few of them one letter away from a picture frame
      if ($urandom_range(9) < 3) begin
        put_text("APIC");
        tag_bytes[tag_bytes.size() - 1 - $urandom_range(3)] = 8'($urandom_range(255));
      end else begin
        repeat (4) tag_bytes.push_back(8'($urandom_range(255)));
      end
      fsz = ($urandom_range(14) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 16));
      if (major == 8'd4) put_synchsafe(fsz[27:0]);
      else put_word32(fsz);
      repeat (2) tag_bytes.push_back(8'($urandom_range(255)));
      repeat (fsz <= 16 ? fsz : $urandom_range(16)) tag_bytes.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(4) != 0) begin
      put_text("APIC");
      put_word32($urandom());
      repeat (3) tag_bytes.push_back(8'($urandom_range(255)));
      pick = $urandom_range(19);
      if (pick < 17) begin
        mime    = (pick % 2 == 0) ? "image/jpeg" : "image/png";
        mut_idx = $urandom_range(mime.len() - 1);
        for (int k = 0; k < mime.len(); k++) begin
          if (pick >= 14 && k == mut_idx && pick != 16) tag_bytes.push_back(any_nonzero());
          else if (!(pick == 16 && k == mime.len() - 1)) tag_bytes.push_back(mime[k]);
        end
        if (pick == 14) tag_bytes.push_back(any_nonzero());
      end else begin
        // long mime string around the text limit
        repeat ($urandom_range(MAX_TEXT_BYTES_DEF - 2, MAX_TEXT_BYTES_DEF + 1))
          tag_bytes.push_back(any_nonzero());
      end
      tag_bytes.push_back(8'h00);
      tag_bytes.push_back(8'($urandom_range(255)));
      dlen = ($urandom_range(9) == 0) ?
             $urandom_range(MAX_TEXT_BYTES_DEF - 2, MAX_TEXT_BYTES_DEF + 1) : $urandom_range(0, 8);
      repeat (dlen) tag_bytes.push_back(any_nonzero());
      tag_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 4)) tag_bytes.push_back(8'($urandom_range(255)));
    end
    body = tag_bytes.size() - 10;
    pick = $urandom_range(19);
    if (pick < 13) tlen = 28'(body + $urandom_range(0, 6));
    else if (pick < 17) tlen = 28'($urandom_range(0, body));
    else if (pick < 19) tlen = 28'($urandom());
    else tlen = '0;
    for (int k = 0; k < 4; k++)
      tag_bytes[6 + k] = {1'($urandom_range(1)), tlen[7*(3-k) +: 7]};
  endfunction

  initial begin
    int unsigned pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 28;
    sink_idle_pct = 61;
    // idle junk, then a bad major version with byte extremes
    send_byte(8'hFF, 1'b0, 1'b1);
    tag_bytes = '{8'h49, 8'h44, 8'h33, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_tag(10, 1'b0);
    // header cut short by end of data
    send_tag(2, 1'b1);
    // restart inside a header, then a version 4 tag of zero length
    send_tag(4, 1'b0);
    tag_bytes = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_tag(10, 1'b0);

    for (int stage = 0; stage < 3; stage++) begin
      src_idle_pct  = (stage == 0) ? 28 : (stage == 1) ? 61 : 0;
      sink_idle_pct = (stage == 0) ? 61 : (stage == 1) ? 28 : 0;
      if (stage == 2) begin
        // stall the sink and push six short bad tags so that the input backs up
        hold_request = 1'b1;
        repeat (6) begin
          tag_bytes.delete();
          tag_bytes.push_back(8'h4A);
          repeat (9) tag_bytes.push_back(8'($urandom_range(255)));
          send_tag(10, 1'b0);
        end
      end
      while (parsed_bytes < ItemTarget * (stage + 1) / 3) begin
        build_tag();
        pick = $urandom_range(19);
        if (pick < 14) send_tag(tag_bytes.size(), $urandom_range(3) == 0);
        else if (pick < 17) send_tag($urandom_range(1, tag_bytes.size()), 1'b1);
        else send_tag($urandom_range(1, tag_bytes.size()), 1'b0);
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (tracker.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/id3pf_pkg.sv
src/id3pf_in_stage.sv
src/id3pf_parser.sv
src/id3pf_out_stage.sv
src/id3v2_picture_frame_finder_top.sv
src/id3pf_checker.sv
tb/sv/id3v2_picture_frame_finder_top_tb.sv
